@@ design/vector_tuple_alu_assert.svh @@
// ----------------------------------------------------------------------------
// vector_tuple_alu assertion macros
// Shared forms for the concurrent checks of the vector unit.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TUPLE_ALU_ASSERT_SVH
`define VECTOR_TUPLE_ALU_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define VTA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vta check failed");

// next-cycle implication
`define VTA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vta check failed");

`endif

@@ design/vta_pkg.sv @@
// ----------------------------------------------------------------------------
// vta_pkg
// Types, constants and helpers shared by the vector unit modules.
// ----------------------------------------------------------------------------
package vta_pkg;

	localparam int W         = 32;
	localparam int FRAC_BITS = 16;
	localparam int QW        = W + FRAC_BITS;   // dividend / quotient width
	localparam int PW        = 2 * W;           // product width
	localparam int SW        = 2 * W + 3;       // pre-saturation sum width
	localparam int QDEPTH    = 4;
	localparam int QAW       = 2;

	localparam logic [3:0] OP_POINT     = 4'd0;
	localparam logic [3:0] OP_VECTOR    = 4'd1;
	localparam logic [3:0] OP_ADD       = 4'd2;
	localparam logic [3:0] OP_SUB       = 4'd3;
	localparam logic [3:0] OP_NEG       = 4'd4;
	localparam logic [3:0] OP_SCALE     = 4'd5;
	localparam logic [3:0] OP_DIVIDE    = 4'd6;
	localparam logic [3:0] OP_MAGNITUDE = 4'd7;
	localparam logic [3:0] OP_NORMALIZE = 4'd8;
	localparam logic [3:0] OP_DOT       = 4'd9;
	localparam logic [3:0] OP_CROSS     = 4'd10;

	localparam logic signed [W:0] FX_ONE = (W+1)'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic [3:0]          operation;
		logic signed [W-1:0] a_x;
		logic signed [W-1:0] a_y;
		logic signed [W-1:0] a_z;
		logic signed [W-1:0] a_w;
		logic signed [W-1:0] b_x;
		logic signed [W-1:0] b_y;
		logic signed [W-1:0] b_z;
		logic signed [W-1:0] b_w;
		logic signed [W-1:0] scalar_in;
	} in_t;

	typedef struct packed {
		logic signed [W-1:0] r_x;
		logic signed [W-1:0] r_y;
		logic signed [W-1:0] r_z;
		logic signed [W-1:0] r_w;
		logic signed [W-1:0] scalar_out;
		logic                overflow_flag;
	} out_t;

	typedef enum logic {CLS_PIPE, CLS_LONG} cls_t;

	typedef struct packed {
		cls_t cls;
		in_t  word;
	} entry_t;

	typedef struct packed {
		logic   head_valid;
		logic   full;
	} qstat_t;

	typedef enum logic [2:0] {L_IDLE, L_SQ, L_SQRT, L_DIV, L_DONE} lstate_t;

	typedef struct packed {
		logic [W-1:0] val;
		logic         ovf;
	} sat_t;

	function automatic sat_t sat_w(input logic signed [SW-1:0] v);
		sat_t r;
		if (v[SW-1:W-1] == {(SW-W+1){v[SW-1]}}) begin
			r.val = v[W-1:0];
			r.ovf = 1'b0;
		end else begin
			r.val = v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic is_long(input logic [3:0] op);
		return (op == OP_DIVIDE) || (op == OP_MAGNITUDE) || (op == OP_NORMALIZE);
	endfunction

endpackage

@@ design/vector_tuple_alu.sv @@
// ----------------------------------------------------------------------------
// vector_tuple_alu
// Four-component Q16.16 vector unit: front queue, short pipe, long unit.
// ----------------------------------------------------------------------------
// A word is taken on any edge with start high and busy low; each result
// shows on result for one cycle with done high and must be taken then.
// Results leave in the order words came in. Point, vector, add, sub, neg,
// scale, dot, cross and unused codes run in a two-stage pipe at one word
// per clock while the long unit is idle. Divide holds the shared long
// unit for its 48 quotient bits (one per clock, in four parallel lanes),
// magnitude for the squares and 32 root steps, and normalize for the
// squares, the root, then the dividers unless the root is zero. While the
// long unit is occupied nothing leaves the 4-word queue, so busy rises once
// the queue fills; short words queued behind a long one resume at full rate.
// ----------------------------------------------------------------------------
`include "vector_tuple_alu_assert.svh"

module vector_tuple_alu (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  vta_pkg::in_t    item,
	output logic            done,
	output vta_pkg::out_t   result
);

	vta_pkg::qstat_t qstat;
	vta_pkg::entry_t head;
	logic            push, pop;
	logic            pipe_go, long_go;
	logic            pipe_active, pipe_vld;
	logic            long_idle, long_done;
	vta_pkg::out_t   pipe_res, long_res;
	logic            done_q;
	vta_pkg::out_t   result_q;

	assign push = start & ~qstat.full;
	assign busy = qstat.full;

	// dispatch only while the long unit is free; this keeps results in order
	assign pop     = qstat.head_valid & long_idle;
	assign pipe_go = pop & (head.cls == vta_pkg::CLS_PIPE);
	assign long_go = pop & (head.cls == vta_pkg::CLS_LONG);

	vta_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.word   (item),
		.pop    (pop),
		.stat   (qstat),
		.head   (head)
	);

	vta_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_go),
		.word      (head.word),
		.active    (pipe_active),
		.out_valid (pipe_vld),
		.res       (pipe_res)
	);

	vta_long u_long (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (long_go),
		.word   (head.word),
		.idle   (long_idle),
		.done   (long_done),
		.res    (long_res)
	);

	// output register: one strobe per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pipe_vld | long_done;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_vld) begin
			result_q <= pipe_res;
		end else if (long_done) begin
			result_q <= long_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// the pipe has drained by the time the long unit finishes
	`VTA_ASSERT_NOW(a_long_alone, long_done, !pipe_active)
	// a taken word is in the queue on the next cycle
	`VTA_ASSERT_NEXT(a_push_lands, push, qstat.head_valid)
	// no dispatch into the long unit while it is working
	`VTA_ASSERT_NOW(a_no_overlap, !long_idle, !pop)

endmodule

@@ design/vta_front.sv @@
// ----------------------------------------------------------------------------
// vta_front
// Takes words in, tags them short or long, and queues them for the back end.
// ----------------------------------------------------------------------------
module vta_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vta_pkg::in_t      word,
	input  logic              pop,
	output vta_pkg::qstat_t   stat,
	output vta_pkg::entry_t   head
);

	vta_pkg::entry_t mem [vta_pkg::QDEPTH];
	vta_pkg::entry_t ent;
	logic [vta_pkg::QAW-1:0] wr_q, rd_q;
	logic [vta_pkg::QAW:0]   cnt_q;

	always_comb begin
		ent.word = word;
		ent.cls  = vta_pkg::is_long(word.operation) ? vta_pkg::CLS_LONG : vta_pkg::CLS_PIPE;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{vta_pkg::QAW{1'b0}}, push} - {{vta_pkg::QAW{1'b0}}, pop};
		end
	end

	assign stat.full       = (cnt_q == (vta_pkg::QAW+1)'(vta_pkg::QDEPTH));
	assign stat.head_valid = (cnt_q != '0);
	assign head            = mem[rd_q];

endmodule

@@ design/vta_pipe.sv @@
// ----------------------------------------------------------------------------
// vta_pipe
// Two-stage datapath for the short operations: products, then sums.
// ----------------------------------------------------------------------------
module vta_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  vta_pkg::in_t    word,
	output logic            active,
	output logic            out_valid,
	output vta_pkg::out_t   res
);

	localparam int W  = vta_pkg::W;
	localparam int PW = vta_pkg::PW;
	localparam int SW = vta_pkg::SW;

	logic signed [W-1:0]  av [4];
	logic signed [W-1:0]  bv [4];
	logic signed [W-1:0]  ma [6];
	logic signed [W-1:0]  mb [6];
	logic signed [W:0]    lin [4];

	logic                 v_s1, v_s2;
	logic [3:0]           op_s1;
	logic signed [PW-1:0] p_s1 [6];
	logic signed [W:0]    lin_s1 [4];
	logic signed [SW-1:0] sum_s2 [5];
	logic                 shft_s2;

	logic signed [SW-1:0] pe [6];
	logic signed [SW-1:0] le [4];
	logic signed [SW-1:0] sum_nx [5];
	logic                 shft_nx;
	logic signed [SW-1:0] sh [5];
	vta_pkg::sat_t        st [5];

	assign av[0] = word.a_x;
	assign av[1] = word.a_y;
	assign av[2] = word.a_z;
	assign av[3] = word.a_w;
	assign bv[0] = word.b_x;
	assign bv[1] = word.b_y;
	assign bv[2] = word.b_z;
	assign bv[3] = word.b_w;

	// multiplier operand select and the linear ops
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ma[k] = '0;
			mb[k] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			lin[i] = '0;
		end
		case (word.operation)
			vta_pkg::OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					ma[i] = av[i];
					mb[i] = word.scalar_in;
				end
			end
			vta_pkg::OP_DOT: begin
				for (int i = 0; i < 4; i++) begin
					ma[i] = av[i];
					mb[i] = bv[i];
				end
			end
			vta_pkg::OP_CROSS: begin
				ma[0] = av[1]; mb[0] = bv[2];
				ma[1] = av[2]; mb[1] = bv[1];
				ma[2] = av[2]; mb[2] = bv[0];
				ma[3] = av[0]; mb[3] = bv[2];
				ma[4] = av[0]; mb[4] = bv[1];
				ma[5] = av[1]; mb[5] = bv[0];
			end
			vta_pkg::OP_POINT, vta_pkg::OP_VECTOR: begin
				for (int i = 0; i < 3; i++) begin
					lin[i] = {av[i][W-1], av[i]};
				end
				lin[3] = (word.operation == vta_pkg::OP_POINT) ? vta_pkg::FX_ONE : '0;
			end
			vta_pkg::OP_ADD: begin
				for (int i = 0; i < 4; i++) begin
					lin[i] = {av[i][W-1], av[i]} + {bv[i][W-1], bv[i]};
				end
			end
			vta_pkg::OP_SUB: begin
				for (int i = 0; i < 4; i++) begin
					lin[i] = {av[i][W-1], av[i]} - {bv[i][W-1], bv[i]};
				end
			end
			vta_pkg::OP_NEG: begin
				for (int i = 0; i < 4; i++) begin
					lin[i] = (W+1)'(0) - {av[i][W-1], av[i]};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s1 <= word.operation;
		for (int k = 0; k < 6; k++) begin
			p_s1[k] <= ma[k] * mb[k];
		end
		for (int i = 0; i < 4; i++) begin
			lin_s1[i] <= lin[i];
		end
	end

	// stage 2: combine lanes at full precision
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pe[k] = {{(SW-PW){p_s1[k][PW-1]}}, p_s1[k]};
		end
		for (int i = 0; i < 4; i++) begin
			le[i] = {{(SW-W-1){lin_s1[i][W]}}, lin_s1[i]};
		end
		for (int l = 0; l < 5; l++) begin
			sum_nx[l] = '0;
		end
		shft_nx = 1'b0;
		case (op_s1)
			vta_pkg::OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					sum_nx[i] = pe[i];
				end
				shft_nx = 1'b1;
			end
			vta_pkg::OP_DOT: begin
				sum_nx[4] = pe[0] + pe[1] + pe[2] + pe[3];
				shft_nx   = 1'b1;
			end
			vta_pkg::OP_CROSS: begin
				sum_nx[0] = pe[0] - pe[1];
				sum_nx[1] = pe[2] - pe[3];
				sum_nx[2] = pe[4] - pe[5];
				shft_nx   = 1'b1;
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					sum_nx[i] = le[i];
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 5; l++) begin
			sum_s2[l] <= sum_nx[l];
		end
		shft_s2 <= shft_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// floor to the fixed-point grid, then clamp
	always_comb begin
		for (int l = 0; l < 5; l++) begin
			sh[l] = shft_s2 ? (sum_s2[l] >>> vta_pkg::FRAC_BITS) : sum_s2[l];
			st[l] = vta_pkg::sat_w(sh[l]);
		end
		res.r_x           = st[0].val;
		res.r_y           = st[1].val;
		res.r_z           = st[2].val;
		res.r_w           = st[3].val;
		res.scalar_out    = st[4].val;
		res.overflow_flag = st[0].ovf | st[1].ovf | st[2].ovf | st[3].ovf | st[4].ovf;
	end

	assign out_valid = v_s2;
	assign active    = v_s1 | v_s2;

endmodule

@@ design/vta_long.sv @@
// ----------------------------------------------------------------------------
// vta_long
// Iterative unit for divide, magnitude and normalize: sum of squares,
// bit-pair square root, and four restoring dividers sharing one divisor.
// ----------------------------------------------------------------------------
module vta_long (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vta_pkg::in_t    word,
	output logic            idle,
	output logic            done,
	output vta_pkg::out_t   res
);

	localparam int W  = vta_pkg::W;
	localparam int QW = vta_pkg::QW;
	localparam int PW = vta_pkg::PW;
	localparam int SW = vta_pkg::SW;
	localparam int CW = $clog2(QW);

	vta_pkg::lstate_t state_q, state_nx;

	logic [CW-1:0]  cnt_q;
	logic [3:0]     op_q;
	logic [W-1:0]   a_q [4];
	logic [W-1:0]   den_q;
	logic [QW-1:0]  num_q [4];
	logic [W-1:0]   rem_q [4];
	logic [QW-1:0]  quo_q [4];
	logic           neg_q [4];
	logic           zdiv_q;
	logic [PW-1:0]  sq_q, acc_q, v_q;
	logic [W-1:0]   root_q;
	logic [W+3:0]   srem_q;
	vta_pkg::out_t  res_q;

	logic [W-1:0]   ain [4];
	logic [W-1:0]   sqa;
	logic [PW:0]    acc_add;
	logic [PW-1:0]  acc_nx;
	logic [W+3:0]   srem_sh, trial, srem_nx;
	logic           sge;
	logic [W-1:0]   root_nx;
	logic [W:0]     r_sh [4];
	logic           dge [4];
	logic [W-1:0]   rem_nx [4];
	logic [QW-1:0]  quo_nx [4];
	logic [QW:0]    qs [4];
	logic [QW:0]    qv [4];
	vta_pkg::sat_t  dres [4];
	vta_pkg::sat_t  mres;
	logic           sq_last, rt_last, dv_last;

	assign ain[0] = word.a_x;
	assign ain[1] = word.a_y;
	assign ain[2] = word.a_z;
	assign ain[3] = word.a_w;

	assign sq_last = (cnt_q == CW'(4));
	assign rt_last = (cnt_q == CW'(W-1));
	assign dv_last = (cnt_q == CW'(QW-1));

	always_comb begin
		sqa     = vta_pkg::abs_w(a_q[cnt_q[1:0]]);
		acc_add = {1'b0, acc_q} + {1'b0, sq_q};
		acc_nx  = acc_add[PW] ? {PW{1'b1}} : acc_add[PW-1:0];

		srem_sh = {srem_q[W+1:0], v_q[PW-1:PW-2]};
		trial   = {2'b00, root_q, 2'b01};
		sge     = (srem_sh >= trial);
		srem_nx = sge ? (srem_sh - trial) : srem_sh;
		root_nx = {root_q[W-2:0], sge};
		mres    = vta_pkg::sat_w({{(SW-W){1'b0}}, root_nx});

		for (int i = 0; i < 4; i++) begin
			r_sh[i]   = {rem_q[i], num_q[i][QW-1]};
			dge[i]    = (r_sh[i] >= {1'b0, den_q});
			rem_nx[i] = dge[i] ? W'(r_sh[i] - {1'b0, den_q}) : r_sh[i][W-1:0];
			quo_nx[i] = {quo_q[i][QW-2:0], dge[i]};
			qs[i]     = {1'b0, quo_nx[i]};
			qv[i]     = neg_q[i] ? ((QW+1)'(0) - qs[i]) : qs[i];
			dres[i]   = vta_pkg::sat_w({{(SW-QW-1){qv[i][QW]}}, qv[i]});
			if (zdiv_q) begin
				// zero divisor: sign of the dividend picks the rail, a zero dividend gives zero
				dres[i].ovf = 1'b1;
				if (a_q[i] == '0) begin
					dres[i].val = '0;
				end else if (a_q[i][W-1]) begin
					dres[i].val = {1'b1, {(W-1){1'b0}}};
				end else begin
					dres[i].val = {1'b0, {(W-1){1'b1}}};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vta_pkg::L_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			vta_pkg::L_IDLE: begin
				if (start) begin
					state_nx = (word.operation == vta_pkg::OP_DIVIDE) ?
						vta_pkg::L_DIV : vta_pkg::L_SQ;
				end
			end
			vta_pkg::L_SQ: begin
				if (sq_last) begin
					state_nx = vta_pkg::L_SQRT;
				end
			end
			vta_pkg::L_SQRT: begin
				if (rt_last) begin
					state_nx = ((op_q == vta_pkg::OP_MAGNITUDE) || (root_nx == '0)) ?
						vta_pkg::L_DONE : vta_pkg::L_DIV;
				end
			end
			vta_pkg::L_DIV: begin
				if (dv_last) begin
					state_nx = vta_pkg::L_DONE;
				end
			end
			vta_pkg::L_DONE: begin
				state_nx = vta_pkg::L_IDLE;
			end
			default: begin
				state_nx = vta_pkg::L_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vta_pkg::L_IDLE: begin
				if (start) begin
					op_q   <= word.operation;
					cnt_q  <= '0;
					acc_q  <= '0;
					res_q  <= '0;
					den_q  <= vta_pkg::abs_w(word.scalar_in);
					zdiv_q <= (word.operation == vta_pkg::OP_DIVIDE) && (word.scalar_in == '0);
					for (int i = 0; i < 4; i++) begin
						a_q[i]   <= ain[i];
						num_q[i] <= {vta_pkg::abs_w(ain[i]), {vta_pkg::FRAC_BITS{1'b0}}};
						rem_q[i] <= '0;
						quo_q[i] <= '0;
						neg_q[i] <= ain[i][W-1] ^
							((word.operation == vta_pkg::OP_DIVIDE) & word.scalar_in[W-1]);
					end
				end
			end
			vta_pkg::L_SQ: begin
				sq_q  <= sqa * sqa;
				if (cnt_q != '0) begin
					acc_q <= acc_nx;
				end
				if (sq_last) begin
					v_q    <= acc_nx;
					srem_q <= '0;
					root_q <= '0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			vta_pkg::L_SQRT: begin
				v_q    <= v_q << 2;
				srem_q <= srem_nx;
				root_q <= root_nx;
				if (rt_last) begin
					den_q <= root_nx;
					cnt_q <= '0;
					if (op_q == vta_pkg::OP_MAGNITUDE) begin
						res_q.scalar_out    <= mres.val;
						res_q.overflow_flag <= mres.ovf;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			vta_pkg::L_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < 4; i++) begin
					num_q[i] <= num_q[i] << 1;
					rem_q[i] <= rem_nx[i];
					quo_q[i] <= quo_nx[i];
				end
				if (dv_last) begin
					res_q.r_x           <= dres[0].val;
					res_q.r_y           <= dres[1].val;
					res_q.r_z           <= dres[2].val;
					res_q.r_w           <= dres[3].val;
					res_q.overflow_flag <= dres[0].ovf | dres[1].ovf | dres[2].ovf | dres[3].ovf;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle = (state_q == vta_pkg::L_IDLE);
	assign done = (state_q == vta_pkg::L_DONE);
	assign res  = res_q;

endmodule
